[rtl/reb_pkg.sv]
`timescale 1ns / 1ps

package reb_pkg;

    localparam int TIME_BITS = 20;
    localparam int GLITCH_W  = 8;
    localparam int DETENT_W  = 4;
    localparam int EDGE_W    = 5;
    localparam int CFG_W     = (TIME_BITS > GLITCH_W) ? TIME_BITS : GLITCH_W;
    localparam int CFG_IDX_W = 2;

    localparam logic [GLITCH_W-1:0]  GLITCH_RST = GLITCH_W'(1);
    localparam logic [DETENT_W-1:0]  DETENT_RST = DETENT_W'(2);
    localparam logic [TIME_BITS-1:0] DEBOUNCE_RST = TIME_BITS'(50000);
    localparam logic [TIME_BITS-1:0] LONG_RST = TIME_BITS'(500000);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GLITCH   = 2'd0,
        CFG_DETENT   = 2'd1,
        CFG_DEBOUNCE = 2'd2,
        CFG_LONG     = 2'd3
    } t_cfg_reg;

    typedef struct packed {
        logic level;
        logic changed;
    } t_filt;

    typedef struct packed {
        logic short_p;
        logic long_p;
    } t_press;

endpackage

[rtl/reb_filter.sv]
`timescale 1ns / 1ps

module reb_filter (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_adv,
    input  logic                          i_raw,
    input  logic [reb_pkg::GLITCH_W-1:0] i_glitch,
    output reb_pkg::t_filt                o_filt
);

    logic                          r_level;
    logic [reb_pkg::GLITCH_W-1:0] r_count;
    logic                          n_level;
    logic [reb_pkg::GLITCH_W-1:0] n_count;
    logic [reb_pkg::GLITCH_W-1:0] c_inc;
    logic                          c_chg;

    always_comb begin
        n_level = r_level;
        n_count = '0;
        c_chg   = 1'b0;
        c_inc   = (r_count != '1) ? r_count + reb_pkg::GLITCH_W'(1) : r_count;
        if (i_raw != r_level) begin
            if (c_inc >= i_glitch) begin
                n_level = i_raw;
                c_chg   = 1'b1;
            end else begin
                n_count = c_inc;
            end
        end
    end

    assign o_filt.level   = n_level;
    assign o_filt.changed = c_chg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level <= 1'b1;
            r_count <= '0;
        end else if (i_adv) begin
            r_level <= n_level;
            r_count <= n_count;
        end
    end

endmodule

[rtl/reb_detent.sv]
`timescale 1ns / 1ps

module reb_detent (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_adv,
    input  reb_pkg::t_filt                i_a,
    input  logic                          i_b_level,
    input  logic [reb_pkg::DETENT_W-1:0] i_detent,
    output logic signed [1:0]             o_step
);

    logic signed [reb_pkg::EDGE_W-1:0] r_edge;
    logic signed [reb_pkg::EDGE_W-1:0] n_edge;
    logic signed [reb_pkg::EDGE_W:0]   c_sum;
    logic signed [reb_pkg::EDGE_W:0]   c_lim;

    always_comb begin
        c_lim  = signed'({{(reb_pkg::EDGE_W+1-reb_pkg::DETENT_W){1'b0}}, i_detent});
        c_sum  = {r_edge[reb_pkg::EDGE_W-1], r_edge}
               + ((i_a.level == i_b_level) ? (reb_pkg::EDGE_W+1)'(1) : '1);
        n_edge = r_edge;
        o_step = 2'sd0;
        if (i_a.changed) begin
            if (c_sum >= c_lim && c_sum > 0) begin
                o_step = 2'sd1;
                n_edge = '0;
            end else if (c_sum <= -c_lim && c_sum < 0) begin
                o_step = -2'sd1;
                n_edge = '0;
            end else begin
                n_edge = c_sum[reb_pkg::EDGE_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_edge <= '0;
        end else if (i_adv) begin
            r_edge <= n_edge;
        end
    end

    a_edge_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_edge != {1'b1, {(reb_pkg::EDGE_W-1){1'b0}}})
        else $error("edge count out of range");

endmodule

[rtl/reb_button.sv]
`timescale 1ns / 1ps

module reb_button (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_adv,
    input  logic                           i_button_level,
    input  logic [reb_pkg::TIME_BITS-1:0] i_debounce,
    input  logic [reb_pkg::TIME_BITS-1:0] i_long,
    output reb_pkg::t_press                o_press
);

    logic                           r_held;
    logic                           r_await;
    logic [reb_pkg::TIME_BITS-1:0] r_hold;
    logic                           n_held;
    logic                           n_await;
    logic [reb_pkg::TIME_BITS-1:0] n_hold;
    logic [reb_pkg::TIME_BITS:0]   c_dur;

    always_comb begin
        n_held          = r_held;
        n_await         = r_await;
        n_hold          = r_hold;
        o_press.short_p = 1'b0;
        o_press.long_p  = 1'b0;
        c_dur           = {1'b0, r_hold} + (reb_pkg::TIME_BITS+1)'(1);
        if (!i_button_level) begin
            if (r_held) begin
                if (r_hold != '1) begin
                    n_hold = r_hold + reb_pkg::TIME_BITS'(1);
                end
            end else if (!r_await) begin
                n_held = 1'b1;
                n_hold = '0;
            end
            if (n_held && n_hold >= i_long) begin
                o_press.long_p = 1'b1;
                n_held         = 1'b0;
                n_await        = 1'b1;
                n_hold         = '0;
            end
        end else begin
            n_await = 1'b0;
            if (r_held) begin
                o_press.short_p = (c_dur >= {1'b0, i_debounce}) && (c_dur < {1'b0, i_long});
                n_held          = 1'b0;
            end
            n_hold = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held  <= 1'b0;
            r_await <= 1'b0;
            r_hold  <= '0;
        end else if (i_adv) begin
            r_held  <= n_held;
            r_await <= n_await;
            r_hold  <= n_hold;
        end
    end

    a_await_not_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_await |-> !r_held)
        else $error("button held while awaiting release");

endmodule

[rtl/rotary_encoder_button_events_core.sv]
`timescale 1ns / 1ps

// Channel   Handshake                   Word
// in        i_in_valid / o_in_stall     i_pin_a, i_pin_b, i_button_level
// out       o_out_valid / i_out_stall   o_step, o_short_press, o_long_press
// cfg       i_cfg_we                    i_cfg_idx, i_cfg_data
//
// One word in, one word out; a new word is taken every cycle when the output flows.
// A word passes from the input register through the filter, detent and button update
// into the result register.
// Synchronous active-low reset: filters idle high, counters clear, registers defaults.
// A stalled output holds the result; the input register still takes one more word.

module rotary_encoder_button_events_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic                            i_pin_a,
    input  logic                            i_pin_b,
    input  logic                            i_button_level,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic signed [1:0]               o_step,
    output logic                            o_short_press,
    output logic                            o_long_press,
    input  logic                            i_cfg_we,
    input  logic [reb_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [reb_pkg::CFG_W-1:0]      i_cfg_data
);

    logic [reb_pkg::GLITCH_W-1:0]  r_glitch;
    logic [reb_pkg::DETENT_W-1:0]  r_detent;
    logic [reb_pkg::TIME_BITS-1:0] r_debounce;
    logic [reb_pkg::TIME_BITS-1:0] r_long;

    logic        r_in_valid;
    logic        r_pin_a;
    logic        r_pin_b;
    logic        r_button;
    logic        r_out_valid;
    logic signed [1:0] r_step;
    logic        r_short;
    logic        r_long_p;

    logic            c_out_free;
    logic            c_adv;
    reb_pkg::t_filt  c_fa;
    reb_pkg::t_filt  c_fb;
    logic signed [1:0] c_step;
    reb_pkg::t_press c_press;

    assign c_out_free = !r_out_valid || !i_out_stall;
    assign c_adv      = r_in_valid && c_out_free;
    assign o_in_stall = r_in_valid && !c_out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_glitch   <= reb_pkg::GLITCH_RST;
            r_detent   <= reb_pkg::DETENT_RST;
            r_debounce <= reb_pkg::DEBOUNCE_RST;
            r_long     <= reb_pkg::LONG_RST;
        end else if (i_cfg_we) begin
            unique case (reb_pkg::t_cfg_reg'(i_cfg_idx))
                reb_pkg::CFG_GLITCH:   r_glitch   <= i_cfg_data[reb_pkg::GLITCH_W-1:0];
                reb_pkg::CFG_DETENT:   r_detent   <= i_cfg_data[reb_pkg::DETENT_W-1:0];
                reb_pkg::CFG_DEBOUNCE: r_debounce <= i_cfg_data[reb_pkg::TIME_BITS-1:0];
                reb_pkg::CFG_LONG:     r_long     <= i_cfg_data[reb_pkg::TIME_BITS-1:0];
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_pin_a  <= i_pin_a;
            r_pin_b  <= i_pin_b;
            r_button <= i_button_level;
        end
    end

    reb_filter u_filt_a (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (c_adv),
        .i_raw    (r_pin_a),
        .i_glitch (r_glitch),
        .o_filt   (c_fa)
    );

    reb_filter u_filt_b (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (c_adv),
        .i_raw    (r_pin_b),
        .i_glitch (r_glitch),
        .o_filt   (c_fb)
    );

    reb_detent u_detent (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_adv     (c_adv),
        .i_a       (c_fa),
        .i_b_level (c_fb.level),
        .i_detent  (r_detent),
        .o_step    (c_step)
    );

    reb_button u_button (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_adv          (c_adv),
        .i_button_level (r_button),
        .i_debounce     (r_debounce),
        .i_long         (r_long),
        .o_press        (c_press)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (c_out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_adv) begin
            r_step   <= c_step;
            r_short  <= c_press.short_p;
            r_long_p <= c_press.long_p;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_step        = r_step;
    assign o_short_press = r_short;
    assign o_long_press  = r_long_p;

    a_adv_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        c_adv |=> r_out_valid)
        else $error("advanced word lost");

    a_step_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_step != -2'sd2))
        else $error("invalid step code");

    a_press_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_short && r_long_p))
        else $error("short and long press together");

endmodule

[dv/reb_event_checker.sv]
`timescale 1ns / 1ps

module reb_event_checker
    import reb_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_stall,
    input  logic                 i_pin_a,
    input  logic                 i_pin_b,
    input  logic                 i_button_level,
    input  logic                 i_out_valid,
    input  logic                 i_out_stall,
    input  logic signed [1:0]    i_step,
    input  logic                 i_short_press,
    input  logic                 i_long_press,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    output int                   o_mismatches,
    output int                   o_pending
);

    typedef struct packed {
        logic signed [1:0] turn;
        logic              short_p;
        logic              long_p;
    } t_event;

    logic [GLITCH_W-1:0]  glitch_len;
    logic [DETENT_W-1:0]  detent_len;
    logic [TIME_BITS-1:0] debounce_len;
    logic [TIME_BITS-1:0] long_len;

    logic                 pin_level [0:1];
    logic [GLITCH_W-1:0]  pin_run   [0:1];
    int                   edge_tally;
    logic                 held;
    logic                 await_rel;
    logic [TIME_BITS-1:0] hold_len;

    t_event               expected_events [$];
    t_event               got_event;
    t_event               want_event;
    int                   flaws = 0;

    function automatic logic settle_pin(input int ch, input logic raw);
        if (raw == pin_level[ch]) begin
            pin_run[ch] = '0;
            return 1'b0;
        end
        if (pin_run[ch] != '1)
            pin_run[ch]++;
        if (pin_run[ch] >= glitch_len) begin
            pin_level[ch] = raw;
            pin_run[ch]   = '0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic t_event encoder_tick(input logic raw_a, input logic raw_b,
                                            input logic btn);
        t_event             ev;
        logic               a_moved;
        int                 lim;
        logic [TIME_BITS:0] held_for;
        ev      = '0;
        a_moved = settle_pin(0, raw_a);
        void'(settle_pin(1, raw_b));
        if (a_moved) begin
            edge_tally += (pin_level[0] == pin_level[1]) ? 1 : -1;
            lim = int'(detent_len);
            if (edge_tally >= lim && edge_tally > 0) begin
                ev.turn    = 2'sd1;
                edge_tally = 0;
            end else if (edge_tally <= -lim && edge_tally < 0) begin
                ev.turn    = -2'sd1;
                edge_tally = 0;
            end
        end
        if (!btn) begin
            if (held) begin
                if (hold_len != '1)
                    hold_len++;
            end else if (!await_rel) begin
                held     = 1'b1;
                hold_len = '0;
            end
            if (held && hold_len >= long_len) begin
                ev.long_p = 1'b1;
                held      = 1'b0;
                await_rel = 1'b1;
                hold_len  = '0;
            end
        end else begin
            await_rel = 1'b0;
            if (held) begin
                held_for = {1'b0, hold_len} + 1'b1;
                if (held_for >= debounce_len && held_for < long_len)
                    ev.short_p = 1'b1;
                held = 1'b0;
            end
            hold_len = '0;
        end
        return ev;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            glitch_len   = GLITCH_RST;
            detent_len   = DETENT_RST;
            debounce_len = DEBOUNCE_RST;
            long_len     = LONG_RST;
            pin_level[0] = 1'b1;
            pin_level[1] = 1'b1;
            pin_run[0]   = '0;
            pin_run[1]   = '0;
            edge_tally   = 0;
            held         = 1'b0;
            await_rel    = 1'b0;
            hold_len     = '0;
            expected_events.delete();
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_reg'(i_cfg_idx))
                    CFG_GLITCH:   glitch_len   = i_cfg_data[GLITCH_W-1:0];
                    CFG_DETENT:   detent_len   = i_cfg_data[DETENT_W-1:0];
                    CFG_DEBOUNCE: debounce_len = i_cfg_data[TIME_BITS-1:0];
                    CFG_LONG:     long_len     = i_cfg_data[TIME_BITS-1:0];
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                got_event.turn    = i_step;
                got_event.short_p = i_short_press;
                got_event.long_p  = i_long_press;
                if (expected_events.size() == 0) begin
                    flaws++;
                    if (flaws <= 10)
                        $display("unexpected word: step %0d short %0b long %0b",
                                 got_event.turn, got_event.short_p, got_event.long_p);
                end else begin
                    want_event = expected_events.pop_front();
                    if (got_event.turn != want_event.turn
                            || got_event.short_p != want_event.short_p
                            || got_event.long_p != want_event.long_p) begin
                        flaws++;
                        if (flaws <= 10) begin
                            $write("word mismatch: expected step %0d short %0b long %0b, ",
                                   want_event.turn, want_event.short_p,
                                   want_event.long_p);
                            $display("got step %0d short %0b long %0b",
                                     got_event.turn, got_event.short_p,
                                     got_event.long_p);
                        end
                    end
                end
            end
            if (i_in_valid && !i_in_stall)
                expected_events.push_back(encoder_tick(i_pin_a, i_pin_b, i_button_level));
        end
        o_pending    <= expected_events.size();
        o_mismatches <= flaws;
    end

endmodule

[dv/tb.sv]
`timescale 1ns / 1ps

module tb;
    import reb_pkg::*;

    localparam int STALL_LIMIT = 3000;

    logic                 clk          = 1'b0;
    logic                 rst_n        = 1'b0;
    logic                 in_valid     = 1'b0;
    logic                 in_stall;
    logic                 pin_a        = 1'b1;
    logic                 pin_b        = 1'b1;
    logic                 button_level = 1'b1;
    logic                 out_valid;
    logic                 out_stall    = 1'b0;
    logic signed [1:0]    step;
    logic                 short_press;
    logic                 long_press;
    logic                 cfg_we       = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx      = '0;
    logic [CFG_W-1:0]     cfg_data     = '0;

    int                   mismatches;
    int                   pending;
    int                   in_idle_pct  = 0;
    int                   out_idle_pct = 0;
    int                   quiet_cycles = 0;

    int                   glitch_cfg   = 1;
    int                   long_cfg     = 1;
    logic [1:0]           quad_pos     = 2'd2;
    logic [1:0]           spin_dir     = 2'd1;
    int                   dwell        = 0;
    logic                 btn_up       = 1'b1;
    int                   btn_left     = 0;

    always #4 clk = ~clk;

    rotary_encoder_button_events_core i_dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_pin_a        (pin_a),
        .i_pin_b        (pin_b),
        .i_button_level (button_level),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_step         (step),
        .o_short_press  (short_press),
        .o_long_press   (long_press),
        .i_cfg_we       (cfg_we),
        .i_cfg_idx      (cfg_idx),
        .i_cfg_data     (cfg_data)
    );

    reb_event_checker i_check (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .i_in_stall     (in_stall),
        .i_pin_a        (pin_a),
        .i_pin_b        (pin_b),
        .i_button_level (button_level),
        .i_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .i_step         (step),
        .i_short_press  (short_press),
        .i_long_press   (long_press),
        .i_cfg_we       (cfg_we),
        .i_cfg_idx      (cfg_idx),
        .i_cfg_data     (cfg_data),
        .o_mismatches   (mismatches),
        .o_pending      (pending)
    );

    always @(posedge clk) begin
        out_stall <= ($urandom_range(0, 99) < out_idle_pct);
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("tb failed");
            $finish;
        end
    end

    task automatic send_word(input logic a, input logic b, input logic btn);
        while ($urandom_range(0, 99) < in_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        pin_a        <= a;
        pin_b        <= b;
        button_level <= btn;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_cfg(input t_cfg_reg idx, input logic [CFG_W-1:0] data);
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_we   <= 1'b0;
    endtask

    task automatic apply_setting(input int glitch, input int detent, input int debounce,
                                 input int long_hold);
        drain();
        write_cfg(CFG_GLITCH, CFG_W'(glitch));
        write_cfg(CFG_DETENT, CFG_W'(detent));
        write_cfg(CFG_DEBOUNCE, CFG_W'(debounce));
        write_cfg(CFG_LONG, CFG_W'(long_hold));
        glitch_cfg = glitch;
        long_cfg   = long_hold;
    endtask

    // walk the quadrature cycle with random dwell and direction, plus timed presses
    task automatic run_turns(input int n_words);
        logic a;
        logic b;
        logic btn;
        int   noise_pct;
        int   press_span;
        noise_pct  = (glitch_cfg > 8) ? 0 : 4;
        press_span = (long_cfg + 4 > 40) ? 40 : long_cfg + 4;
        for (int n = 0; n < n_words; n++) begin
            if (dwell == 0) begin
                if ($urandom_range(0, 9) == 0)
                    spin_dir = -spin_dir;
                if ($urandom_range(0, 99) < 85)
                    quad_pos = quad_pos + spin_dir;
                dwell = glitch_cfg + $urandom_range(0, 3);
            end else begin
                dwell--;
            end
            a = ^quad_pos;
            b = quad_pos[1];
            if ($urandom_range(0, 99) < noise_pct)
                a = ~a;
            if ($urandom_range(0, 99) < noise_pct)
                b = ~b;
            if (btn_left == 0) begin
                btn_up   = ~btn_up;
                btn_left = btn_up ? $urandom_range(1, 8) : $urandom_range(1, press_span);
            end else begin
                btn_left--;
            end
            btn = btn_up;
            if ($urandom_range(0, 99) < 3)
                btn = ~btn;
            send_word(a, b, btn);
        end
    endtask

    initial begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        in_idle_pct  = 12;
        out_idle_pct = 86;

        send_word(1'b0, 1'b1, 1'b1);
        send_word(1'b0, 1'b0, 1'b1);
        send_word(1'b1, 1'b0, 1'b1);

        // zero glitch, zero detent, zero long-press time
        apply_setting(0, 0, 0, 0);
        send_word(1'b0, 1'b0, 1'b1);
        send_word(1'b1, 1'b0, 1'b1);
        send_word(1'b1, 1'b1, 1'b0);
        send_word(1'b0, 1'b1, 1'b0);
        send_word(1'b1, 1'b1, 1'b0);
        send_word(1'b1, 1'b1, 1'b1);

        apply_setting(1, 1, 2, 3);
        send_word(1'b1, 1'b1, 1'b0);
        send_word(1'b1, 1'b1, 1'b1);
        send_word(1'b1, 1'b1, 1'b0);
        send_word(1'b1, 1'b1, 1'b0);
        send_word(1'b1, 1'b1, 1'b1);
        send_word(1'b0, 1'b1, 1'b0);
        send_word(1'b0, 1'b0, 1'b0);
        send_word(1'b1, 1'b0, 1'b0);
        send_word(1'b1, 1'b1, 1'b0);
        send_word(1'b1, 1'b1, 1'b0);
        send_word(1'b1, 1'b1, 1'b1);

        apply_setting(2, 4, 3, 12);
        run_turns(300);
        apply_setting(255, 1, 5, 20);
        run_turns(550);

        drain();
        in_idle_pct  = 86;
        out_idle_pct = 12;
        apply_setting(0, 15, 1048575, 1048575);
        run_turns(300);
        apply_setting(1, 1, 0, 1);
        run_turns(150);

        drain();
        in_idle_pct  = 0;
        out_idle_pct = 0;
        apply_setting(3, 2, 1, 6);
        run_turns(200);
        apply_setting(1, 3, 2, 9);
        run_turns(150);

        drain();
        if (mismatches == 0 && pending == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule
